### sv/rabf_pkg.sv
// shared constants, types and codes for the rectangle blend and fade block
`default_nettype none

package rabf_pkg;

  localparam int unsigned MaxWidth   = 128;
  localparam int unsigned MaxHeight  = 128;
  localparam int unsigned ColW       = $clog2(MaxWidth);
  localparam int unsigned RowW       = $clog2(MaxHeight);
  localparam int unsigned ColEndW    = ColW + 1;
  localparam int unsigned RowEndW    = RowW + 1;
  localparam int unsigned AddrW      = RowW + ColW;
  localparam int unsigned Depth      = MaxWidth * MaxHeight;
  localparam int unsigned ChanW      = 8;
  localparam int unsigned PixW       = 3 * ChanW;
  localparam int unsigned ProdW      = 2 * ChanW;
  localparam int unsigned CountW     = 15;
  localparam int unsigned CfgW       = 8;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);
  localparam int unsigned QCntW      = QPtrW + 1;
  localparam int unsigned ApbAddrW   = 3;
  localparam int unsigned ApbDataW   = 32;
  localparam int unsigned RegSelBit  = 2;

  localparam logic RegFrameWidth  = 1'b0;
  localparam logic RegFrameHeight = 1'b1;

  localparam logic [CfgW-1:0] FrameReset = CfgW'(128);

  typedef enum logic [1:0] {
    OP_BLEND = 2'd0,
    OP_FADE  = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    KIND_NOP,
    KIND_BLEND,
    KIND_FADE,
    KIND_READ
  } kind_e;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_RUN,
    BK_FLUSH,
    BK_FINISH
  } back_state_e;

  typedef struct packed {
    logic [1:0] opcode;
    logic [6:0] left;
    logic [6:0] top;
    logic [7:0] rect_w;
    logic [7:0] rect_h;
    logic [7:0] fill_red;
    logic [7:0] fill_green;
    logic [7:0] fill_blue;
    logic [7:0] fill_alpha;
  } req_t;

  typedef struct packed {
    logic [7:0]  pixel_red;
    logic [7:0]  pixel_green;
    logic [7:0]  pixel_blue;
    logic [14:0] pixels_touched;
  } rsp_t;

  typedef struct packed {
    kind_e               kind;
    logic [ColW-1:0]     x0;
    logic [ColEndW-1:0]  x1;
    logic [RowW-1:0]     y0;
    logic [RowEndW-1:0]  y1;
    logic [ChanW-1:0]    inv;
    logic [ProdW-1:0]    pre_r;
    logic [ProdW-1:0]    pre_g;
    logic [ProdW-1:0]    pre_b;
  } cmd_t;

endpackage

`default_nettype wire

### sv/rabf_ram.sv
// generic single write port, single read port ram with registered read
`default_nettype none

module rabf_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 16384
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

### sv/rabf_front.sv
// front end: request handshake, clipping and classification into commands
`default_nettype none

module rabf_front (
  input  wire logic                      req_valid_i,
  output logic                           req_stall_o,
  input  wire rabf_pkg::req_t            req_i,
  input  wire logic [rabf_pkg::CfgW-1:0] frame_width_i,
  input  wire logic [rabf_pkg::CfgW-1:0] frame_height_i,
  input  wire logic                      full_i,
  input  wire logic                      clearing_i,
  output logic                           push_o,
  output rabf_pkg::cmd_t                 cmd_o
);
  import rabf_pkg::*;

  logic [CfgW-1:0] fw;
  logic [CfgW-1:0] fh;
  logic [CfgW:0]   xe_sum;
  logic [CfgW:0]   ye_sum;
  logic [CfgW-1:0] xe;
  logic [CfgW-1:0] ye;
  logic            blend_empty;
  logic            read_in;

  assign fw = (frame_width_i > CfgW'(MaxWidth)) ? CfgW'(MaxWidth) : frame_width_i;
  assign fh = (frame_height_i > CfgW'(MaxHeight)) ? CfgW'(MaxHeight) : frame_height_i;

  assign xe_sum = (CfgW+1)'(req_i.left) + (CfgW+1)'(req_i.rect_w);
  assign ye_sum = (CfgW+1)'(req_i.top) + (CfgW+1)'(req_i.rect_h);
  assign xe = (xe_sum < {1'b0, fw}) ? xe_sum[CfgW-1:0] : fw;
  assign ye = (ye_sum < {1'b0, fh}) ? ye_sum[CfgW-1:0] : fh;
  assign blend_empty = (CfgW'(req_i.left) >= xe) || (CfgW'(req_i.top) >= ye);
  assign read_in = (CfgW'(req_i.left) < fw) && (CfgW'(req_i.top) < fh);

  assign req_stall_o = full_i || clearing_i;
  assign push_o = req_valid_i && !req_stall_o;

  always_comb begin
    cmd_o.kind  = KIND_NOP;
    cmd_o.x0    = ColW'(req_i.left);
    cmd_o.y0    = RowW'(req_i.top);
    cmd_o.x1    = ColEndW'(req_i.left);
    cmd_o.y1    = RowEndW'(req_i.top);
    cmd_o.inv   = 8'hFF - req_i.fill_alpha;
    cmd_o.pre_r = req_i.fill_alpha * req_i.fill_red;
    cmd_o.pre_g = req_i.fill_alpha * req_i.fill_green;
    cmd_o.pre_b = req_i.fill_alpha * req_i.fill_blue;
    unique case (op_e'(req_i.opcode))
      OP_BLEND: begin
        if (!blend_empty) begin
          cmd_o.kind = KIND_BLEND;
          cmd_o.x1   = ColEndW'(xe);
          cmd_o.y1   = RowEndW'(ye);
        end
      end
      OP_FADE: begin
        if ((fw != '0) && (fh != '0)) begin
          cmd_o.kind = KIND_FADE;
          cmd_o.x0   = '0;
          cmd_o.y0   = '0;
          cmd_o.x1   = ColEndW'(fw);
          cmd_o.y1   = RowEndW'(fh);
        end
      end
      OP_READ: begin
        if (read_in) begin
          cmd_o.kind = KIND_READ;
          cmd_o.x1   = ColEndW'(req_i.left) + 1'b1;
          cmd_o.y1   = RowEndW'(req_i.top) + 1'b1;
        end
      end
      OP_NONE: begin
        cmd_o.kind = KIND_NOP;
      end
      default: begin
        cmd_o.kind = KIND_NOP;
      end
    endcase
  end

endmodule

`default_nettype wire

### sv/rabf_fifo.sv
// short command queue between front end and pixel engine
`default_nettype none

module rabf_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire rabf_pkg::cmd_t cmd_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                empty_o,
  output rabf_pkg::cmd_t      head_o
);
  import rabf_pkg::*;

  cmd_t             slot_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q;
  logic [QPtrW-1:0] rd_ptr_q;
  logic [QCntW-1:0] cnt_q;

  assign full_o  = (cnt_q == QCntW'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

### sv/rabf_back.sv
// pixel engine: clearing pass, rectangle walk, read-modify-write, result register
`default_nettype none

module rabf_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire rabf_pkg::cmd_t head_i,
  input  wire logic           empty_i,
  output logic                pop_o,
  output logic                clearing_o,
  output logic                rsp_valid_o,
  input  wire logic           rsp_stall_i,
  output rabf_pkg::rsp_t      rsp_o
);
  import rabf_pkg::*;

  function automatic logic [ChanW-1:0] blend_chan(
    input logic [ProdW-1:0] pre,
    input logic [ChanW-1:0] inv,
    input logic [ChanW-1:0] old
  );
    logic [ProdW-1:0] prod;
    logic [ProdW:0]   sum;
    prod = inv * old;
    sum  = (ProdW+1)'(pre) + (ProdW+1)'(prod);
    return sum[ProdW-1:ChanW];
  endfunction

  function automatic logic [ChanW-1:0] fade_chan(input logic [ChanW-1:0] old);
    return (old == '0) ? old : old - 1'b1;
  endfunction

  back_state_e         state_q;
  back_state_e         state_d;
  logic [AddrW-1:0]    clr_q;
  logic [ColW-1:0]     col_q;
  logic [RowW-1:0]     row_q;
  logic [CountW-1:0]   cnt_q;
  logic                pend_q;
  logic [AddrW-1:0]    waddr_q;
  logic [PixW-1:0]     rgb_q;
  logic                rsp_valid_q;
  rsp_t                rsp_q;

  logic [ColEndW-1:0]  col_inc;
  logic [RowEndW-1:0]  row_inc;
  logic                row_end;
  logic                last;
  logic                slot_free;
  logic                ram_re;
  logic                ram_we;
  logic [AddrW-1:0]    ram_waddr;
  logic [PixW-1:0]     ram_wdata;
  logic [PixW-1:0]     ram_rdata;
  logic [PixW-1:0]     new_pix;

  assign col_inc   = ColEndW'(col_q) + 1'b1;
  assign row_inc   = RowEndW'(row_q) + 1'b1;
  assign row_end   = (col_inc == head_i.x1);
  assign last      = row_end && (row_inc == head_i.y1);
  assign slot_free = !rsp_valid_q || !rsp_stall_i;

  always_comb begin
    if (head_i.kind == KIND_BLEND) begin
      new_pix = {blend_chan(head_i.pre_r, head_i.inv, ram_rdata[PixW-1 -: ChanW]),
                 blend_chan(head_i.pre_g, head_i.inv, ram_rdata[ProdW-1 -: ChanW]),
                 blend_chan(head_i.pre_b, head_i.inv, ram_rdata[ChanW-1:0])};
    end else begin
      new_pix = {fade_chan(ram_rdata[PixW-1 -: ChanW]),
                 fade_chan(ram_rdata[ProdW-1 -: ChanW]),
                 fade_chan(ram_rdata[ChanW-1:0])};
    end
  end

  always_comb begin
    state_d = state_q;
    pop_o   = 1'b0;
    ram_re  = 1'b0;
    unique case (state_q)
      BK_CLEAR: begin
        if (clr_q == '1) begin
          state_d = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (!empty_i) begin
          state_d = (head_i.kind == KIND_NOP) ? BK_FINISH : BK_RUN;
        end
      end
      BK_RUN: begin
        ram_re = 1'b1;
        if (last) begin
          state_d = BK_FLUSH;
        end
      end
      BK_FLUSH: begin
        state_d = BK_FINISH;
      end
      BK_FINISH: begin
        if (slot_free) begin
          pop_o   = 1'b1;
          state_d = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  assign clearing_o = (state_q == BK_CLEAR);

  // clearing pass owns the write port until it ends
  always_comb begin
    if (state_q == BK_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_q;
      ram_wdata = '0;
    end else begin
      ram_we    = pend_q && ((head_i.kind == KIND_BLEND) || (head_i.kind == KIND_FADE));
      ram_waddr = waddr_q;
      ram_wdata = new_pix;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_CLEAR;
      clr_q       <= '0;
      pend_q      <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= (state_q == BK_RUN);
      if (state_q == BK_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (pop_o) begin
        rsp_valid_q <= 1'b1;
      end else if (!rsp_stall_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    waddr_q <= {row_q, col_q};
    unique case (state_q)
      BK_IDLE: begin
        col_q <= head_i.x0;
        row_q <= head_i.y0;
        cnt_q <= '0;
        rgb_q <= '0;
      end
      BK_RUN: begin
        cnt_q <= cnt_q + 1'b1;
        if (row_end) begin
          col_q <= head_i.x0;
          row_q <= row_inc[RowW-1:0];
        end else begin
          col_q <= col_inc[ColW-1:0];
        end
      end
      BK_FLUSH: begin
        if (head_i.kind == KIND_READ) begin
          rgb_q <= ram_rdata;
        end
      end
      BK_CLEAR, BK_FINISH: begin
      end
      default: begin
      end
    endcase
    if (pop_o) begin
      rsp_q.pixel_red      <= rgb_q[PixW-1 -: ChanW];
      rsp_q.pixel_green    <= rgb_q[ProdW-1 -: ChanW];
      rsp_q.pixel_blue     <= rgb_q[ChanW-1:0];
      rsp_q.pixels_touched <= cnt_q;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  rabf_ram #(
    .Width (PixW),
    .Depth (Depth)
  ) u_frame_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i ({row_q, col_q}),
    .rdata_o (ram_rdata)
  );

endmodule

`default_nettype wire

### sv/rect_alpha_blend_and_fade.sv
// top level: frame store with rectangle blend, fade and pixel read, apb frame size registers
//
// channel   dir  handshake                       payload
// request   in   req_valid_i / req_stall_o       req_i  (rabf_pkg::req_t)
// result    out  rsp_valid_o / rsp_stall_i       rsp_o  (rabf_pkg::rsp_t)
// config    in   psel penable pwrite pready      paddr pwdata prdata
//
// blend and fade visit each pixel of the clipped rectangle or frame in turn, in the pixel
// engine's single read-modify-write pass over the frame store ram; an empty command skips
// the walk and a read visits one pixel. after reset a clearing pass writes black to all
// 16384 pixels, one per cycle, and req_stall_o stays high meanwhile. a two-entry queue
// lets requests be taken while the engine works; a held result stalls only the engine.
`default_nettype none

module rect_alpha_blend_and_fade (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          req_valid_i,
  output logic                               req_stall_o,
  input  wire rabf_pkg::req_t                req_i,
  output logic                               rsp_valid_o,
  input  wire logic                          rsp_stall_i,
  output rabf_pkg::rsp_t                     rsp_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [rabf_pkg::ApbAddrW-1:0] paddr,
  input  wire logic [rabf_pkg::ApbDataW-1:0] pwdata,
  output logic      [rabf_pkg::ApbDataW-1:0] prdata,
  output logic                               pready
);
  import rabf_pkg::*;

  logic [CfgW-1:0] frame_width_q;
  logic [CfgW-1:0] frame_height_q;
  logic            cfg_wr;
  logic            push;
  logic            pop;
  logic            full;
  logic            empty;
  logic            clearing;
  cmd_t            cmd;
  cmd_t            head;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[RegSelBit] == RegFrameHeight) ? ApbDataW'(frame_height_q)
                                                       : ApbDataW'(frame_width_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FrameReset;
      frame_height_q <= FrameReset;
    end else if (cfg_wr) begin
      if (paddr[RegSelBit] == RegFrameWidth) begin
        frame_width_q <= pwdata[CfgW-1:0];
      end else begin
        frame_height_q <= pwdata[CfgW-1:0];
      end
    end
  end

  rabf_front u_front (
    .req_valid_i    (req_valid_i),
    .req_stall_o    (req_stall_o),
    .req_i          (req_i),
    .frame_width_i  (frame_width_q),
    .frame_height_i (frame_height_q),
    .full_i         (full),
    .clearing_i     (clearing),
    .push_o         (push),
    .cmd_o          (cmd)
  );

  rabf_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (head)
  );

  rabf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (empty),
    .pop_o       (pop),
    .clearing_o  (clearing),
    .rsp_valid_o (rsp_valid_o),
    .rsp_stall_i (rsp_stall_i),
    .rsp_o       (rsp_o)
  );

endmodule

`default_nettype wire

### sim/tb_frame_pkg.sv
// frame store tracker: predicts blend, fade and read replies and checks the block's replies
package tb_frame_pkg;

  import rabf_pkg::*;

  localparam int unsigned Opaque = 255;

  class frame_tracker;
    bit [ChanW-1:0] store [MaxHeight][MaxWidth][3];
    bit [CfgW-1:0]  width_reg;
    bit [CfgW-1:0]  height_reg;
    rsp_t           replies_due[$];
    int unsigned    errors;

    function new();
      width_reg  = FrameReset;
      height_reg = FrameReset;
      errors     = 0;
    endfunction

    function void write_reg(logic sel, bit [CfgW-1:0] value);
      if (sel == RegFrameWidth) begin
        width_reg = value;
      end else begin
        height_reg = value;
      end
    endfunction

    function int unsigned used_cols();
      return (width_reg < MaxWidth) ? width_reg : MaxWidth;
    endfunction

    function int unsigned used_rows();
      return (height_reg < MaxHeight) ? height_reg : MaxHeight;
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s expected %0d got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void take_command(req_t c);
      rsp_t           r;
      int unsigned    cols;
      int unsigned    rows;
      int unsigned    x_end;
      int unsigned    y_end;
      int unsigned    alpha;
      int unsigned    inv;
      int unsigned    mix;
      int unsigned    touched;
      bit [ChanW-1:0] tint [3];
      r       = '0;
      touched = 0;
      cols    = used_cols();
      rows    = used_rows();
      case (c.opcode)
        OP_BLEND: begin
          x_end = c.left;
          x_end += c.rect_w;
          if (x_end > cols) x_end = cols;
          y_end = c.top;
          y_end += c.rect_h;
          if (y_end > rows) y_end = rows;
          alpha = c.fill_alpha;
          inv   = Opaque - alpha;
          tint  = '{c.fill_red, c.fill_green, c.fill_blue};
          for (int unsigned y = c.top; y < y_end; y++) begin
            for (int unsigned x = c.left; x < x_end; x++) begin
              for (int ch = 0; ch < 3; ch++) begin
                mix = (alpha * tint[ch] + inv * store[y][x][ch]) >> ChanW;
                store[y][x][ch] = mix[ChanW-1:0];
              end
              touched++;
            end
          end
        end
        OP_FADE: begin
          for (int unsigned y = 0; y < rows; y++) begin
            for (int unsigned x = 0; x < cols; x++) begin
              for (int ch = 0; ch < 3; ch++) begin
                if (store[y][x][ch] != 0) store[y][x][ch]--;
              end
              touched++;
            end
          end
        end
        OP_READ: begin
          if (c.left < cols && c.top < rows) begin
            r.pixel_red   = store[c.top][c.left][0];
            r.pixel_green = store[c.top][c.left][1];
            r.pixel_blue  = store[c.top][c.left][2];
            touched = 1;
          end
        end
        default: begin
        end
      endcase
      r.pixels_touched = 15'(touched);
      replies_due.push_back(r);
    endfunction

    function void match_reply(rsp_t got);
      rsp_t want;
      if (replies_due.size() == 0) begin
        $error("reply %h with no request outstanding", got);
        errors++;
        return;
      end
      want = replies_due.pop_front();
      check_field("pixel_red", want.pixel_red, got.pixel_red);
      check_field("pixel_green", want.pixel_green, got.pixel_green);
      check_field("pixel_blue", want.pixel_blue, got.pixel_blue);
      check_field("pixels_touched", want.pixels_touched, got.pixels_touched);
    endfunction
  endclass

endpackage

### sim/tb_top.sv
// top-level testbench: drives requests, replies and frame size registers of the blend block
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rabf_pkg::*;
  import tb_frame_pkg::*;

  localparam int unsigned StallLimit = 200000;
  localparam int unsigned LongHold   = 400;
  localparam int unsigned Drain      = 32;

  logic                clk_i;
  logic                rst_ni;
  logic                req_valid_i;
  logic                req_stall_o;
  req_t                req_i;
  logic                rsp_valid_o;
  logic                rsp_stall_i;
  rsp_t                rsp_o;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  frame_tracker mirror = new();
  bit quiet = 1'b0;
  bit hold_pending = 1'b0;

  rect_alpha_blend_and_fade dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_stall_o (req_stall_o),
    .req_i       (req_i),
    .rsp_valid_o (rsp_valid_o),
    .rsp_stall_i (rsp_stall_i),
    .rsp_o       (rsp_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  task automatic set_frame_reg(input logic sel, input bit [CfgW-1:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= ApbAddrW'(sel) << RegSelBit;
    pwdata  <= ApbDataW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    mirror.write_reg(sel, value);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    mirror.check_field((sel == RegFrameWidth) ? "frame_width" : "frame_height",
                       ApbDataW'(value), prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_request(input req_t c);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      req_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    req_valid_i <= 1'b1;
    req_i       <= c;
    do @(posedge clk_i); while (req_stall_o);
    mirror.take_command(c);
  endtask

  task automatic settle();
    req_valid_i <= 1'b0;
    while (mirror.replies_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  function automatic req_t make_cmd(op_e op, int unsigned left, int unsigned top,
                                    int unsigned w, int unsigned h, int unsigned red,
                                    int unsigned green, int unsigned blue,
                                    int unsigned alpha);
    req_t c;
    c.opcode     = op;
    c.left       = 7'(left);
    c.top        = 7'(top);
    c.rect_w     = 8'(w);
    c.rect_h     = 8'(h);
    c.fill_red   = 8'(red);
    c.fill_green = 8'(green);
    c.fill_blue  = 8'(blue);
    c.fill_alpha = 8'(alpha);
    return c;
  endfunction

  function automatic req_t pick_command();
    req_t        c;
    int unsigned roll;
    int unsigned cols;
    int unsigned rows;
    c    = req_t'({$urandom, $urandom});
    cols = mirror.used_cols();
    rows = mirror.used_rows();
    roll = $urandom_range(0, 99);
    if (roll < 45) begin
      c.opcode = OP_BLEND;
    end else if (roll < 85) begin
      c.opcode = OP_READ;
    end else if (roll < 95) begin
      c.opcode = OP_FADE;
    end else begin
      c.opcode = OP_NONE;
    end
    if ($urandom_range(0, 7) != 0 && cols > 0 && rows > 0) begin
      c.left = 7'($urandom_range(0, cols - 1));
      c.top  = 7'($urandom_range(0, rows - 1));
    end
    if ($urandom_range(0, 9) != 0) begin
      c.rect_w = 8'($urandom_range(0, 12));
      c.rect_h = 8'($urandom_range(0, 12));
    end
    return c;
  endfunction

  function automatic bit [CfgW-1:0] pick_size();
    if ($urandom_range(0, 7) == 0) return CfgW'($urandom_range(0, 255));
    return CfgW'($urandom_range(1, 24));
  endfunction

  initial begin : stimulus
    req_t noise;
    rst_ni      = 1'b0;
    req_valid_i = 1'b0;
    req_i       = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // full frame at reset size
    send_request(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0));
    send_request(make_cmd(OP_FADE, 0, 0, 0, 0, 0, 0, 0, 0));
    send_request(make_cmd(OP_BLEND, 0, 0, 128, 128, 255, 0, 170, 255));
    send_request(make_cmd(OP_READ, 127, 127, 0, 0, 0, 0, 0, 0));
    send_request(make_cmd(OP_BLEND, 10, 10, 4, 4, 255, 255, 255, 0));
    send_request(make_cmd(OP_BLEND, 120, 120, 128, 128, 18, 200, 99, 128));
    send_request(make_cmd(OP_BLEND, 5, 5, 0, 9, 1, 2, 3, 200));
    send_request(make_cmd(OP_BLEND, 0, 3, 255, 1, 77, 88, 99, 254));
    send_request(make_cmd(OP_FADE, 0, 0, 0, 0, 0, 0, 0, 0));
    send_request(make_cmd(OP_READ, 10, 10, 0, 0, 0, 0, 0, 0));
    send_request(make_cmd(OP_READ, 127, 0, 0, 0, 0, 0, 0, 0));
    send_request(make_cmd(OP_READ, 121, 125, 0, 0, 0, 0, 0, 0));
    send_request(make_cmd(OP_READ, 0, 3, 0, 0, 0, 0, 0, 0));
    noise        = req_t'({$urandom, $urandom});
    noise.opcode = OP_NONE;
    send_request(noise);

    // empty frame
    settle();
    set_frame_reg(RegFrameWidth, 8'd0);
    set_frame_reg(RegFrameHeight, 8'd0);
    send_request(make_cmd(OP_BLEND, 0, 0, 10, 10, 9, 9, 9, 255));
    send_request(make_cmd(OP_FADE, 0, 0, 0, 0, 0, 0, 0, 0));
    send_request(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0));

    // register above the store size
    settle();
    set_frame_reg(RegFrameWidth, 8'd255);
    set_frame_reg(RegFrameHeight, 8'd255);
    send_request(make_cmd(OP_BLEND, 100, 100, 200, 200, 40, 250, 7, 200));
    send_request(make_cmd(OP_READ, 127, 127, 0, 0, 0, 0, 0, 0));

    // single pixel frame
    settle();
    set_frame_reg(RegFrameWidth, 8'd1);
    set_frame_reg(RegFrameHeight, 8'd1);
    send_request(make_cmd(OP_FADE, 0, 0, 0, 0, 0, 0, 0, 0));
    send_request(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0));
    send_request(make_cmd(OP_READ, 1, 0, 0, 0, 0, 0, 0, 0));
    send_request(make_cmd(OP_READ, 0, 1, 0, 0, 0, 0, 0, 0));
    send_request(make_cmd(OP_BLEND, 0, 0, 5, 5, 255, 128, 1, 255));

    for (int phase = 0; phase < 5; phase++) begin
      settle();
      set_frame_reg(RegFrameWidth, pick_size());
      set_frame_reg(RegFrameHeight, pick_size());
      if (phase == 2) hold_pending = 1'b1;
      if (phase == 4) quiet = 1'b1;
      repeat (16) send_request(pick_command());
    end

    settle();
    repeat (Drain) @(posedge clk_i);
    if (mirror.errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  initial begin : result_side
    int unsigned hold;
    hold        = 0;
    rsp_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rsp_valid_o && !rsp_stall_i) mirror.match_reply(rsp_o);
      if (hold_pending) begin
        hold_pending = 1'b0;
        hold         = LongHold;
      end
      if (hold > 0) begin
        hold--;
        rsp_stall_i <= 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        hold        = $urandom_range(0, 7);
        rsp_stall_i <= 1'b1;
      end else begin
        rsp_stall_i <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < StallLimit) begin
      @(posedge clk_i);
      if ((req_valid_i && !req_stall_o) || (rsp_valid_o && !rsp_stall_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("tb_top failed");
    $finish;
  end

endmodule
